// ----- rtl/npsrch_pkg.sv -----
package npsrch_pkg;

    localparam int COORD_BITS      = 16;
    localparam int IDX_BITS        = 4;
    localparam int CNT_BITS        = 5;
    localparam int DIST_BITS       = 33;
    localparam int DIFF_BITS       = COORD_BITS + 1;
    localparam int SQ_BITS         = 2 * COORD_BITS;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int CNT_RESET       = 10;

    localparam int S_TDATA_BITS = 40;
    localparam int M_TDATA_BITS = 72;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

endpackage

// ----- rtl/nearest_point_search.sv -----
// Channel       Direction  Beat contents
// s_axis        in         tdata: entry_index, coord_x, coord_y; tuser: cmd
// m_axis        out        tdata: nearest_x, nearest_y, nearest_index,
//                          nearest_distance_sq
// cfg           in         points_in_use, written whenever cfg_we is high
//
// A load beat writes the table entry it names, if within the table, and gives no result.
// A query beat holds the input off until its result is in the output register;
// one distance pipeline walks one table entry per cycle.
// A finished result waits in the output register, and the next query stalls at
// its end until that register has been taken.
// Reset sets points_in_use to 10; the point table is not cleared.
module nearest_point_search
#(
    parameter int TABLE_DEPTH = npsrch_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [3:0] entry_index, [19:4] coord_x, [35:20] coord_y, [39:36] zero
    input  logic [npsrch_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [15:0] nearest_x, [31:16] nearest_y, [35:32] nearest_index,
    // [68:36] nearest_distance_sq, [71:69] zero
    output logic [npsrch_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
    input  logic                                 cfg_we,
    input  logic [npsrch_pkg::CNT_BITS-1:0]      cfg_wdata
);

    import npsrch_pkg::*;

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DW     = $clog2(TABLE_DEPTH + 1);
    localparam int CW     = (DW > CNT_BITS) ? DW : CNT_BITS;
    localparam int PAD_IN = M_TDATA_BITS - (2 * COORD_BITS + IDX_BITS + DIST_BITS);

    localparam logic [CW-1:0] DEPTH_CW = CW'(TABLE_DEPTH);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } state_t;

    state_t                       state_reg;
    logic [CNT_BITS-1:0]          count_cfg_reg;

    logic [COORD_BITS-1:0]        mem_x [TABLE_DEPTH];
    logic [COORD_BITS-1:0]        mem_y [TABLE_DEPTH];

    logic [IDX_BITS-1:0]          in_index;
    logic [COORD_BITS-1:0]        in_x;
    logic [COORD_BITS-1:0]        in_y;
    logic                         in_beat;
    logic                         load_ok;

    logic [CW-1:0]                count_ext;
    logic [CW-1:0]                count_clamp;
    logic [AW-1:0]                last_next;

    logic [COORD_BITS-1:0]        qx_reg;
    logic [COORD_BITS-1:0]        qy_reg;
    logic [AW-1:0]                last_reg;
    logic [AW-1:0]                rd_addr_reg;
    logic                         issue_reg;

    logic                         v1_reg, v2_reg, v3_reg;
    logic                         l1_reg, l2_reg, l3_reg;
    logic [AW-1:0]                i1_reg, i2_reg, i3_reg;
    logic [COORD_BITS-1:0]        x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic signed [DIFF_BITS-1:0]  dx_reg, dy_reg;
    logic signed [2*DIFF_BITS-1:0] prod_x, prod_y;
    logic [SQ_BITS-1:0]           sqx_reg, sqy_reg;
    logic [DIST_BITS-1:0]         dist_sum;
    logic                         take_new;

    logic [DIST_BITS-1:0]         best_d_reg;
    logic [AW-1:0]                best_i_reg;
    logic [COORD_BITS-1:0]        best_x_reg;
    logic [COORD_BITS-1:0]        best_y_reg;
    logic [DIST_BITS-1:0]         best_d_next;
    logic [AW-1:0]                best_i_next;
    logic [COORD_BITS-1:0]        best_x_next;
    logic [COORD_BITS-1:0]        best_y_next;

    logic                         m_valid_reg;
    logic [M_TDATA_BITS-1:0]      m_data_reg;

    assign in_index = s_axis_tdata[IDX_BITS-1:0];
    assign in_x     = s_axis_tdata[IDX_BITS +: COORD_BITS];
    assign in_y     = s_axis_tdata[IDX_BITS + COORD_BITS +: COORD_BITS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign load_ok       = (32'(in_index) < 32'(TABLE_DEPTH));

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb
    begin
        count_ext = CW'(count_cfg_reg);
        if (count_ext == '0)
        begin
            count_clamp = CW'(1);
        end
        else if (count_ext > DEPTH_CW)
        begin
            count_clamp = DEPTH_CW;
        end
        else
        begin
            count_clamp = count_ext;
        end
        last_next = AW'(count_clamp - CW'(1));
    end

    // Table storage with a registered read port for the walk.
    always_ff @(posedge clk)
    begin
        if (in_beat && (cmd_t'(s_axis_tuser) == CMD_LOAD) && load_ok)
        begin
            mem_x[AW'(in_index)] <= in_x;
            mem_y[AW'(in_index)] <= in_y;
        end
        x1_reg <= mem_x[rd_addr_reg];
        y1_reg <= mem_y[rd_addr_reg];
    end

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;

    // Distance pipeline: difference, square, then sum and compare.
    always_ff @(posedge clk)
    begin
        i1_reg  <= rd_addr_reg;
        dx_reg  <= $signed({x1_reg[COORD_BITS-1], x1_reg})
                   - $signed({qx_reg[COORD_BITS-1], qx_reg});
        dy_reg  <= $signed({y1_reg[COORD_BITS-1], y1_reg})
                   - $signed({qy_reg[COORD_BITS-1], qy_reg});
        i2_reg  <= i1_reg;
        x2_reg  <= x1_reg;
        y2_reg  <= y1_reg;
        sqx_reg <= prod_x[SQ_BITS-1:0];
        sqy_reg <= prod_y[SQ_BITS-1:0];
        i3_reg  <= i2_reg;
        x3_reg  <= x2_reg;
        y3_reg  <= y2_reg;
    end

    assign dist_sum = DIST_BITS'(sqx_reg) + DIST_BITS'(sqy_reg);
    assign take_new = (i3_reg == '0) || (dist_sum < best_d_reg);

    always_comb
    begin
        best_d_next = best_d_reg;
        best_i_next = best_i_reg;
        best_x_next = best_x_reg;
        best_y_next = best_y_reg;
        if (v3_reg && take_new)
        begin
            best_d_next = dist_sum;
            best_i_next = i3_reg;
            best_x_next = x3_reg;
            best_y_next = y3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_cfg_reg <= CNT_BITS'(CNT_RESET);
            qx_reg        <= '0;
            qy_reg        <= '0;
            last_reg      <= '0;
            rd_addr_reg   <= '0;
            issue_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            l1_reg        <= 1'b0;
            l2_reg        <= 1'b0;
            l3_reg        <= 1'b0;
            best_d_reg    <= '0;
            best_i_reg    <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_cfg_reg <= cfg_wdata;
            end

            if (m_valid_reg && m_axis_tready && (state_reg != ST_RESULT))
            begin
                m_valid_reg <= 1'b0;
            end

            v1_reg <= issue_reg;
            l1_reg <= issue_reg && (rd_addr_reg == last_reg);
            v2_reg <= v1_reg;
            l2_reg <= l1_reg;
            v3_reg <= v2_reg;
            l3_reg <= l2_reg;

            best_d_reg <= best_d_next;
            best_i_reg <= best_i_next;
            best_x_reg <= best_x_next;
            best_y_reg <= best_y_next;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat && (cmd_t'(s_axis_tuser) == CMD_QUERY))
                    begin
                        qx_reg      <= in_x;
                        qy_reg      <= in_y;
                        last_reg    <= last_next;
                        rd_addr_reg <= '0;
                        issue_reg   <= 1'b1;
                        state_reg   <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (issue_reg)
                    begin
                        if (rd_addr_reg == last_reg)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            rd_addr_reg <= rd_addr_reg + AW'(1);
                        end
                    end
                    if (v3_reg && l3_reg)
                    begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {{PAD_IN{1'b0}}, best_d_reg,
                                        IDX_BITS'(best_i_reg), best_y_reg, best_x_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The distance pipeline is empty whenever a new beat can be taken.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!issue_reg && !v1_reg && !v2_reg && !v3_reg))
        else $error("distance pipeline busy while input is ready");

    // The last entry leaving the pipeline always ends the walk.
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && l3_reg) |=> (state_reg == ST_RESULT))
        else $error("walk did not end after the last entry");

    // Reads are issued only during a walk.
    a_issue_walk: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> (state_reg == ST_WALK))
        else $error("table read issued outside a walk");

    // A result is loaded only when the output register is free or being taken.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready) |=> m_valid_reg)
        else $error("pending result lost");

endmodule
